// ----- sv/sidta_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII unit.
// Used by sidta_ctrl, sidta_dp and the top level; depends on nothing.
package sidta_pkg;

	localparam int VALUE_W = 32;
	localparam int CHAR_W = 7;
	localparam int DIGIT_W = 4;

	localparam logic [CHAR_W-1:0] CH_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CH_NINE = 7'd57;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;

	// floor(n / 10) == (n * RECIP10) >> RECIP10_SHIFT for every 32-bit n.
	localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SHIFT = 35;
	localparam int QUOT_W = 2 * VALUE_W - RECIP10_SHIFT;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic neg;
		logic out_free;
		logic cnt_one;
	} status_t;

endpackage

// ----- sv/sidta_ctrl.sv -----
// Controller state machine for the signed integer to decimal ASCII unit.
// Depends on sidta_pkg; drives sidta_dp through cmd_t and reads status_t.
module sidta_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sidta_pkg::status_t  status,
	output sidta_pkg::cmd_t     cmd
);

	sidta_pkg::state_t state_q;
	sidta_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidta_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			sidta_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = sidta_pkg::ST_DIV;
				end
			end
			sidta_pkg::ST_DIV: begin
				if (status.div_last) begin
					state_next = status.neg ? sidta_pkg::ST_SIGN : sidta_pkg::ST_EMIT;
				end
			end
			sidta_pkg::ST_SIGN: begin
				if (status.out_free) begin
					state_next = sidta_pkg::ST_EMIT;
				end
			end
			sidta_pkg::ST_EMIT: begin
				if (status.out_free && status.cnt_one) begin
					state_next = sidta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = sidta_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			sidta_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sidta_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			sidta_pkg::ST_SIGN: begin
				cmd.emit_sign = status.out_free;
			end
			sidta_pkg::ST_EMIT: begin
				cmd.emit_digit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// An accepted request always starts the digit extraction next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == sidta_pkg::ST_DIV))
		else $error("accepted request did not start division");

endmodule

// ----- sv/sidta_dp.sv -----
// Datapath of the signed integer to decimal ASCII unit: magnitude register,
// divide-by-ten step, digit buffer and output register. Depends on sidta_pkg.
module sidta_dp #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [sidta_pkg::VALUE_W-1:0]     value,
	input  sidta_pkg::cmd_t                   cmd,
	output sidta_pkg::status_t                status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sidta_pkg::CHAR_W-1:0]      char_code,
	output logic                              last_char
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS - 1);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [sidta_pkg::VALUE_W-1:0]   mag_q;
	logic                            neg_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [sidta_pkg::DIGIT_W-1:0]   digs_q [MAX_DIGITS];
	logic                            out_valid_q;
	logic [sidta_pkg::CHAR_W-1:0]    char_q;
	logic                            last_q;

	logic [2*sidta_pkg::VALUE_W-1:0] prod;
	logic [sidta_pkg::QUOT_W-1:0]    quot;
	logic [sidta_pkg::DIGIT_W-1:0]   rem;
	logic [sidta_pkg::DIGIT_W-1:0]   quot_x10_lo;
	logic [CNT_W-1:0]                rd_cnt;
	logic [sidta_pkg::DIGIT_W-1:0]   rd_digit;
	logic                            out_free;

	assign prod = (2*sidta_pkg::VALUE_W)'(mag_q) * (2*sidta_pkg::VALUE_W)'(sidta_pkg::RECIP10);
	assign quot = prod[2*sidta_pkg::VALUE_W-1:sidta_pkg::RECIP10_SHIFT];
	// The remainder is below ten, so its low four bits come from the low
	// four bits of value minus ten times the quotient.
	assign quot_x10_lo = sidta_pkg::DIGIT_W'({quot[sidta_pkg::DIGIT_W-2:0], 1'b0})
		+ sidta_pkg::DIGIT_W'({quot[sidta_pkg::DIGIT_W-4:0], 3'b000});
	assign rem = mag_q[sidta_pkg::DIGIT_W-1:0] - quot_x10_lo;

	assign rd_cnt = cnt_q - CNT_ONE;
	assign rd_digit = digs_q[rd_cnt[IDX_W-1:0]];
	assign out_free = !out_valid_q || out_ready;

	assign status.div_last = (quot == '0) || (cnt_q == CNT_FULL);
	assign status.neg = neg_q;
	assign status.out_free = out_free;
	assign status.cnt_one = (cnt_q == CNT_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_ONE;
			end else if (cmd.emit_digit) begin
				cnt_q <= rd_cnt;
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[sidta_pkg::VALUE_W-1];
			mag_q <= value[sidta_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
		end else if (cmd.div_step) begin
			mag_q <= sidta_pkg::VALUE_W'(quot);
			digs_q[cnt_q[IDX_W-1:0]] <= rem;
		end
		if (cmd.emit_sign) begin
			char_q <= sidta_pkg::CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sidta_pkg::CH_ZERO + sidta_pkg::CHAR_W'(rd_digit);
			last_q <= (cnt_q == CNT_ONE);
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond buffer size");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit |-> (cnt_q != '0))
		else $error("digit emitted from an empty buffer");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem <= 4'd9))
		else $error("division step produced a remainder above nine");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (char_q != sidta_pkg::CH_MINUS))
		else $error("minus sign flagged as last character");

endmodule

// ----- sv/signed_int_to_decimal_ascii_unit.sv -----
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Input stream s_*: one request per integer, tdata[31:0] = value (two's complement).
// Output stream m_*: one character per transfer, most significant first;
// tdata[6:0] = char_code ('-' or '0'..'9'), tdata[7] = 0; tlast marks the
// final character of a number. Zero gives the single character '0'.
// Operation: after a request is taken the divide-by-ten unit produces one digit
// per cycle (nd = number of digits, at most MAX_DIGITS), then the output
// register presents one character per cycle while m_tready does not stall it
// (nd characters, plus one for a minus). The single shared divide step and
// the one-character output register serve one number at a time: the next
// request is taken as soon as the last character of the previous number sits
// in the output register, and not before.
// If MAX_DIGITS is below the digit count, only the low MAX_DIGITS digits appear.
// A stalled receiver (m_tready low) holds the current character and pauses
// character output; division goes on. Reset (arst_n low) empties the output
// register and returns the controller to idle; no clearing pass is needed.
// Depends on sidta_pkg, sidta_ctrl and sidta_dp.
module signed_int_to_decimal_ascii_unit #(
	parameter int MAX_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] char_code, [7] zero fill
	output logic        m_tlast   // last_char
);

	sidta_pkg::cmd_t                  cmd;
	sidta_pkg::status_t               status;
	logic [sidta_pkg::CHAR_W-1:0]     char_code;

	sidta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sidta_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.char_code (char_code),
		.last_char (m_tlast)
	);

	assign m_tdata = {1'b0, char_code};

endmodule
